// ===== rtl/core/imuari_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU rotate/integrate package
// Widths, constants and shared types for the acceleration rotation and
// dead-reckoning integration block.
// ----------------------------------------------------------------------------
package imuari_pkg;

    // Fraction bits of the quaternion components.
    localparam int QUAT_FRAC_BITS = 14;

    localparam int QUAT_W   = 16;
    localparam int ACC_IN_W = 16;
    localparam int DT_W     = 20;
    localparam int DB_W     = 16;
    localparam int ACC_W    = 17;
    localparam int VEL_W    = 48;
    localparam int POS_W    = 63;

    // Sum of two quaternion products, and that sum times one acceleration.
    localparam int PROD_W    = 2 * QUAT_W + 1;
    localparam int PA_W      = PROD_W + ACC_IN_W;
    localparam int ROT_SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int SUM_W     = ((ROT_SHIFT > PA_W) ? ROT_SHIFT : PA_W) + 4;

    // Velocity update and the split velocity-times-time product.
    localparam int DV_W    = VEL_W + 1;
    localparam int SPLIT_W = VEL_W / 2;
    localparam int PART_W  = (VEL_W - SPLIT_W) + DT_W + 1;
    localparam int PD_W    = POS_W + 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DB_W-1:0] DEADBAND_RST = DB_W'(38);

    // One sample after the front end: rotation matrix rows and the raw vectors.
    typedef struct packed {
        logic signed [PROD_W-1:0]   px0;
        logic signed [PROD_W-1:0]   px1;
        logic signed [PROD_W-1:0]   px2;
        logic signed [PROD_W-1:0]   py0;
        logic signed [PROD_W-1:0]   py1;
        logic signed [PROD_W-1:0]   py2;
        logic signed [ACC_IN_W-1:0] ax;
        logic signed [ACC_IN_W-1:0] ay;
        logic signed [ACC_IN_W-1:0] az;
        logic [DT_W-1:0]            dt;
        logic                       zero_step;
    } t_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_VEL,
        ST_MUL,
        ST_POS
    } t_state;

endpackage

// ===== rtl/core/imuari_front.sv =====
// ----------------------------------------------------------------------------
// IMU rotate/integrate front end
// Accepts samples, forms the quaternion matrix coefficients and tags samples
// with a zero time step.
// ----------------------------------------------------------------------------
module imuari_front import imuari_pkg::*; (
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [QUAT_W-1:0]   i_quat_w,
    input  logic signed [QUAT_W-1:0]   i_quat_x,
    input  logic signed [QUAT_W-1:0]   i_quat_y,
    input  logic signed [QUAT_W-1:0]   i_quat_z,
    input  logic signed [ACC_IN_W-1:0] i_body_accel_x,
    input  logic signed [ACC_IN_W-1:0] i_body_accel_y,
    input  logic signed [ACC_IN_W-1:0] i_body_accel_z,
    input  logic [DT_W-1:0]            i_time_step_us,
    input  logic                       i_full,
    output logic                       o_push,
    output t_item                      o_item
);

    logic signed [2*QUAT_W-1:0] w_ww, w_xx, w_yy, w_xy, w_wz, w_xz, w_wy, w_yz, w_wx;

    assign w_ww = i_quat_w * i_quat_w;
    assign w_xx = i_quat_x * i_quat_x;
    assign w_yy = i_quat_y * i_quat_y;
    assign w_xy = i_quat_x * i_quat_y;
    assign w_wz = i_quat_w * i_quat_z;
    assign w_xz = i_quat_x * i_quat_z;
    assign w_wy = i_quat_w * i_quat_y;
    assign w_yz = i_quat_y * i_quat_z;
    assign w_wx = i_quat_w * i_quat_x;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // Rows of the transposed rotation matrix, without the factor two and
    // without the minus one on the diagonal.
    always_comb begin
        o_item.px0       = PROD_W'(w_ww) + PROD_W'(w_xx);
        o_item.px1       = PROD_W'(w_xy) + PROD_W'(w_wz);
        o_item.px2       = PROD_W'(w_xz) - PROD_W'(w_wy);
        o_item.py0       = PROD_W'(w_xy) - PROD_W'(w_wz);
        o_item.py1       = PROD_W'(w_ww) + PROD_W'(w_yy);
        o_item.py2       = PROD_W'(w_yz) + PROD_W'(w_wx);
        o_item.ax        = i_body_accel_x;
        o_item.ay        = i_body_accel_y;
        o_item.az        = i_body_accel_z;
        o_item.dt        = i_time_step_us;
        o_item.zero_step = (i_time_step_us == '0);
    end

endmodule

// ===== rtl/core/imuari_queue.sv =====
// ----------------------------------------------------------------------------
// IMU rotate/integrate sample queue
// Short first-in first-out buffer between the front end and the integrator.
// ----------------------------------------------------------------------------
module imuari_queue import imuari_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_head
);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== rtl/core/imuari_back.sv =====
// ----------------------------------------------------------------------------
// IMU rotate/integrate back end
// Sequencer that rotates one queued sample, applies the deadband, integrates
// velocity and position, and holds the result in an output register.
// ----------------------------------------------------------------------------
module imuari_back import imuari_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_deadband_we,
    input  logic [DB_W-1:0]            i_deadband,
    input  logic                       i_empty,
    input  t_item                      i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [ACC_W-1:0]    o_world_accel_x,
    output logic signed [ACC_W-1:0]    o_world_accel_y,
    output logic signed [VEL_W-1:0]    o_speed_x,
    output logic signed [VEL_W-1:0]    o_speed_y,
    output logic signed [POS_W-1:0]    o_place_x,
    output logic signed [POS_W-1:0]    o_place_y
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (ROT_SHIFT - 1);
    localparam logic signed [SUM_W:0]   ACC_MAX    = (SUM_W + 1)'((2 ** (ACC_W - 1)) - 1);
    localparam logic signed [SUM_W:0]   ACC_MIN    = -ACC_MAX - 1;
    localparam logic [VEL_W-1:0]        VEL_MAX    = {1'b0, {(VEL_W - 1){1'b1}}};
    localparam logic [VEL_W-1:0]        VEL_MIN    = {1'b1, {(VEL_W - 1){1'b0}}};
    localparam logic signed [PD_W-1:0]  POS_MAX    = PD_W'({1'b0, {(POS_W - 1){1'b1}}});
    localparam logic signed [PD_W-1:0]  POS_MIN    = -POS_MAX - 1;

    // Rounded matrix row times acceleration, minus the diagonal term,
    // then deadband and saturation.
    function automatic logic signed [ACC_W-1:0] rotate_out(
        input logic signed [PA_W-1:0]     a,
        input logic signed [PA_W-1:0]     b,
        input logic signed [PA_W-1:0]     c,
        input logic signed [ACC_IN_W-1:0] diag,
        input logic [DB_W-1:0]            db
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W:0]   r;
        logic [SUM_W:0]          mag;
        logic signed [ACC_W-1:0] res;
        s   = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        s   = (s <<< 1) + ROUND_HALF;
        r   = (SUM_W + 1)'(s >>> ROT_SHIFT) - (SUM_W + 1)'(diag);
        mag = r[SUM_W] ? $unsigned(-r) : $unsigned(r);
        if (mag < (SUM_W + 1)'(db)) begin
            res = '0;
        end else if (r > ACC_MAX) begin
            res = ACC_MAX[ACC_W-1:0];
        end else if (r < ACC_MIN) begin
            res = ACC_MIN[ACC_W-1:0];
        end else begin
            res = r[ACC_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(
        input logic signed [VEL_W-1:0] vel,
        input logic signed [ACC_W-1:0] w,
        input logic [DT_W-1:0]         dt
    );
        logic signed [DV_W-1:0] d;
        logic signed [DV_W-1:0] s;
        logic signed [VEL_W-1:0] res;
        d = DV_W'(w) * DV_W'($signed({1'b0, dt}));
        s = DV_W'(vel) + d;
        if (s[DV_W-1] != s[DV_W-2]) begin
            res = s[DV_W-1] ? VEL_MIN : VEL_MAX;
        end else begin
            res = s[VEL_W-1:0];
        end
        return res;
    endfunction

    // Position step from the two partial products of velocity times time.
    function automatic logic signed [POS_W-1:0] sat_pos(
        input logic signed [POS_W-1:0]  pos,
        input logic signed [PART_W-1:0] hi,
        input logic signed [PART_W-1:0] lo
    );
        logic signed [PD_W-1:0]  d;
        logic signed [PD_W-1:0]  s;
        logic signed [POS_W-1:0] res;
        d = (PD_W'(hi) <<< SPLIT_W) + PD_W'(lo);
        s = PD_W'(pos) + d;
        if (s > POS_MAX) begin
            res = POS_MAX[POS_W-1:0];
        end else if (s < POS_MIN) begin
            res = POS_MIN[POS_W-1:0];
        end else begin
            res = s[POS_W-1:0];
        end
        return res;
    endfunction

    t_state                     r_state, n_state;
    t_item                      r_cur;
    logic signed [PA_W-1:0]     r_pa [6];
    logic signed [ACC_W-1:0]    r_wx, r_wy;
    logic signed [VEL_W-1:0]    r_vel_x, r_vel_y;
    logic signed [POS_W-1:0]    r_pos_x, r_pos_y;
    logic signed [PART_W-1:0]   r_hi_x, r_hi_y, r_lo_x, r_lo_y;
    logic [DB_W-1:0]            r_deadband;
    logic                       r_out_valid;
    logic signed [ACC_W-1:0]    r_out_wx, r_out_wy;
    logic signed [VEL_W-1:0]    r_out_vx, r_out_vy;
    logic signed [POS_W-1:0]    r_out_px, r_out_py;
    logic signed [POS_W-1:0]    n_pos_x, n_pos_y;
    logic signed [PART_W-1:0]   w_dt_s;
    logic                       w_out_free;
    logic                       w_finish;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_dt_s     = PART_W'($signed({1'b0, r_cur.dt}));
    assign n_pos_x    = sat_pos(r_pos_x, r_hi_x, r_lo_x);
    assign n_pos_y    = sat_pos(r_pos_y, r_hi_y, r_lo_y);

    always_comb begin
        case (r_state)
            ST_LOAD: n_state = i_empty ? ST_LOAD : ST_SUM;
            ST_SUM:  n_state = ST_VEL;
            ST_VEL:  n_state = r_cur.zero_step ? ST_POS : ST_MUL;
            ST_MUL:  n_state = ST_POS;
            ST_POS:  n_state = w_out_free ? ST_LOAD : ST_POS;
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            ST_LOAD: o_pop    = !i_empty;
            ST_POS:  w_finish = w_out_free;
            default: begin
                o_pop    = 1'b0;
                w_finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
            r_deadband  <= DEADBAND_RST;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else begin
            r_state <= n_state;
            if (i_deadband_we) begin
                r_deadband <= i_deadband;
            end
            if (r_state == ST_VEL) begin
                r_vel_x <= sat_vel(r_vel_x, r_wx, r_cur.dt);
                r_vel_y <= sat_vel(r_vel_y, r_wy, r_cur.dt);
            end
            if (w_finish) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur   <= i_head;
            r_pa[0] <= PA_W'($signed(i_head.px0)) * PA_W'($signed(i_head.ax));
            r_pa[1] <= PA_W'($signed(i_head.px1)) * PA_W'($signed(i_head.ay));
            r_pa[2] <= PA_W'($signed(i_head.px2)) * PA_W'($signed(i_head.az));
            r_pa[3] <= PA_W'($signed(i_head.py0)) * PA_W'($signed(i_head.ax));
            r_pa[4] <= PA_W'($signed(i_head.py1)) * PA_W'($signed(i_head.ay));
            r_pa[5] <= PA_W'($signed(i_head.py2)) * PA_W'($signed(i_head.az));
        end
        if (r_state == ST_SUM) begin
            r_wx <= rotate_out(r_pa[0], r_pa[1], r_pa[2], r_cur.ax, r_deadband);
            r_wy <= rotate_out(r_pa[3], r_pa[4], r_pa[5], r_cur.ay, r_deadband);
        end
        // A zero time step leaves the position untouched.
        if (r_state == ST_VEL && r_cur.zero_step) begin
            r_hi_x <= '0;
            r_hi_y <= '0;
            r_lo_x <= '0;
            r_lo_y <= '0;
        end
        if (r_state == ST_MUL) begin
            r_hi_x <= PART_W'($signed(r_vel_x[VEL_W-1:SPLIT_W])) * w_dt_s;
            r_hi_y <= PART_W'($signed(r_vel_y[VEL_W-1:SPLIT_W])) * w_dt_s;
            r_lo_x <= PART_W'($signed({1'b0, r_vel_x[SPLIT_W-1:0]})) * w_dt_s;
            r_lo_y <= PART_W'($signed({1'b0, r_vel_y[SPLIT_W-1:0]})) * w_dt_s;
        end
        if (w_finish) begin
            r_out_wx <= r_wx;
            r_out_wy <= r_wy;
            r_out_vx <= r_vel_x;
            r_out_vy <= r_vel_y;
            r_out_px <= n_pos_x;
            r_out_py <= n_pos_y;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_world_accel_x = r_out_wx;
    assign o_world_accel_y = r_out_wy;
    assign o_speed_x       = r_out_vx;
    assign o_speed_y       = r_out_vy;
    assign o_place_x       = r_out_px;
    assign o_place_y       = r_out_py;

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POS && w_out_free) |=> o_out_valid)
        else $error("finished sample not presented on the output");

    a_vel_only_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_VEL) |=> ($stable(r_vel_x) && $stable(r_vel_y)))
        else $error("velocity changed outside the velocity step");

    a_zero_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VEL && r_cur.zero_step) |=> ($stable(r_vel_x) && $stable(r_vel_y)))
        else $error("zero time step changed the velocity");

endmodule

// ===== rtl/core/imu_accel_rotate_integrate.sv =====
// ----------------------------------------------------------------------------
// IMU acceleration rotation and dead-reckoning integrator
// Rotates body acceleration by a quaternion, applies a deadband and
// integrates x and y into saturating velocity and position.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) takes one beat per IMU sample:
//   quaternion, body acceleration and elapsed time. The output channel
//   (o_out_valid / i_out_ready) returns one beat per sample with the rotated
//   x/y acceleration and the updated velocity and position.
//   The user writes the deadband register (i_deadband_we / i_deadband)
//   only while the block is idle, which it does not enforce. Resets to 38.
//   Each input beat is registered in the queue, then the back-end sequencer
//   steps through load, sum, velocity, multiply and position, one sample at
//   a time, skipping the multiply step when the time step is zero; the
//   result then goes to the output register.
//   A two-entry queue sits between the front end and the sequencer, so up to
//   three samples (one in the sequencer, two in the queue) are taken while the result register waits on the receiver.
//   When the receiver stalls, the sequencer holds in its last step and the
//   queue fills; then o_in_ready drops.
//   Reset clears velocity, position, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module imu_accel_rotate_integrate import imuari_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_deadband_we,
    input  logic [DB_W-1:0]            i_deadband,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [QUAT_W-1:0]   i_quat_w,
    input  logic signed [QUAT_W-1:0]   i_quat_x,
    input  logic signed [QUAT_W-1:0]   i_quat_y,
    input  logic signed [QUAT_W-1:0]   i_quat_z,
    input  logic signed [ACC_IN_W-1:0] i_body_accel_x,
    input  logic signed [ACC_IN_W-1:0] i_body_accel_y,
    input  logic signed [ACC_IN_W-1:0] i_body_accel_z,
    input  logic [DT_W-1:0]            i_time_step_us,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [ACC_W-1:0]    o_world_accel_x,
    output logic signed [ACC_W-1:0]    o_world_accel_y,
    output logic signed [VEL_W-1:0]    o_speed_x,
    output logic signed [VEL_W-1:0]    o_speed_y,
    output logic signed [POS_W-1:0]    o_place_x,
    output logic signed [POS_W-1:0]    o_place_y
);

    logic  w_full, w_empty, w_push, w_pop;
    t_item w_item, w_head;

    imuari_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_quat_w       (i_quat_w),
        .i_quat_x       (i_quat_x),
        .i_quat_y       (i_quat_y),
        .i_quat_z       (i_quat_z),
        .i_body_accel_x (i_body_accel_x),
        .i_body_accel_y (i_body_accel_y),
        .i_body_accel_z (i_body_accel_z),
        .i_time_step_us (i_time_step_us),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_item         (w_item)
    );

    imuari_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    imuari_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_deadband_we   (i_deadband_we),
        .i_deadband      (i_deadband),
        .i_empty         (w_empty),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_world_accel_x (o_world_accel_x),
        .o_world_accel_y (o_world_accel_y),
        .o_speed_x       (o_speed_x),
        .o_speed_y       (o_speed_y),
        .o_place_x       (o_place_x),
        .o_place_y       (o_place_y)
    );

endmodule
